// ----- sv/volume_scalar_colormap_macros.svh -----
// ----------------------------------------------------------------------------
// Volume scalar colormap assertion macros
// Shared concurrent assertion forms for the colormap block.
// ----------------------------------------------------------------------------
`ifndef VOLUME_SCALAR_COLORMAP_MACROS_SVH
`define VOLUME_SCALAR_COLORMAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Volume scalar colormap package
// Widths, register indexes, control types and the hue table generator.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int EXT_W      = 11;
    localparam int ADDR_W     = 30;
    localparam int COLOR_W    = 8;
    localparam int LEVEL_W    = 17;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF = 17'h08000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_EXTENT    = 3'd5;

    localparam logic MODE_RAMP = 1'b0;
    localparam logic MODE_HUE  = 1'b1;

    // Hue table geometry. The phase repeats four times over the table, so only
    // one quarter of it is stored.
    localparam int HUE_TABLE_SIZE = 4096;
    localparam int HUE_IDX_W      = $clog2(HUE_TABLE_SIZE);
    localparam int HUE_ROM_DEPTH  = HUE_TABLE_SIZE / 4;
    localparam int HUE_ROM_AW     = $clog2(HUE_ROM_DEPTH);

    localparam longint unsigned Q30_ONE       = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
    localparam int unsigned     QUARTER_TURN  = 3072;
    localparam int unsigned     FULL_TURN     = 12288;
    localparam int unsigned     THIRD_TURN    = 4096;
    localparam longint          INTENSITY_Q16 = 64'sd8355836;

    typedef struct packed {
        logic load;
        logic mul;
        logic level;
        logic index;
        logic rom;
        logic out_load;
    } vsc_cmd_t;

    typedef struct packed {
        logic out_free;
    } vsc_status_t;

    typedef logic [3*COLOR_W-1:0] rgb_t;
    typedef rgb_t hue_rom_t [HUE_ROM_DEPTH];

    // Sine over the first quarter turn, Q30, from a Taylor series in Horner form.
    function automatic longint unsigned quarter_sine(input longint unsigned x);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned a;
        longint unsigned s;
        t  = (x * HALF_PI_Q30) / QUARTER_TURN;
        t2 = (t * t) >> 30;
        a  = Q30_ONE - t2 / 72;
        a  = Q30_ONE - ((t2 * a) >> 30) / 42;
        a  = Q30_ONE - ((t2 * a) >> 30) / 20;
        a  = Q30_ONE - ((t2 * a) >> 30) / 6;
        s  = (t * a) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return s;
    endfunction

    function automatic longint sine_q30(input int unsigned ph);
        int unsigned p;
        int unsigned q;
        int unsigned r;
        longint      s;
        p = ph % FULL_TURN;
        q = p / QUARTER_TURN;
        r = p % QUARTER_TURN;
        if (q[0]) begin
            s = longint'(quarter_sine(64'(QUARTER_TURN - r)));
        end else begin
            s = longint'(quarter_sine(64'(r)));
        end
        return (q >= 2) ? -s : s;
    endfunction

    function automatic logic [COLOR_W-1:0] hue_component(input int unsigned ph);
        longint v;
        longint c;
        v = longint'(Q30_ONE) + (sine_q30(ph) * 3) / 4;
        if (v < 0) begin
            v = 0;
        end
        c = (v * INTENSITY_Q16) >>> 46;
        return c[COLOR_W-1:0];
    endfunction

    // One entry per table index within one period (a quarter of the table): red in the low byte.
    function automatic hue_rom_t build_hue_rom();
        hue_rom_t    rom;
        int unsigned ph;
        for (int unsigned i = 0; i < HUE_ROM_DEPTH; i++) begin
            ph = (i * 4 * FULL_TURN / HUE_TABLE_SIZE) % FULL_TURN;
            rom[i] = {hue_component(ph + THIRD_TURN),
                      hue_component(ph),
                      hue_component(ph + FULL_TURN - THIRD_TURN)};
        end
        return rom;
    endfunction

endpackage

// ----- sv/vsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Volume scalar colormap controller
// Sequences one word through capture, multiply, level, index, table and output.
// ----------------------------------------------------------------------------
module vsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  vsc_pkg::vsc_status_t status,
    output vsc_pkg::vsc_cmd_t    cmd
);
    import vsc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_LEVEL = 3'd2;
    localparam logic [2:0] ST_INDEX = 3'd3;
    localparam logic [2:0] ST_ROM   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                cmd.level  = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX: begin
                cmd.index  = 1'b1;
                state_next = ST_ROM;
            end
            ST_ROM: begin
                cmd.rom    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Wait here until the previous result has left the output register.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/vsc_datapath.sv -----
// ----------------------------------------------------------------------------
// Volume scalar colormap datapath
// Configuration registers, position counters, level arithmetic, hue table and
// the output register.
// ----------------------------------------------------------------------------
module vsc_datapath #(
    parameter int MAX_EXTENT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  vsc_pkg::vsc_cmd_t               cmd,
    output vsc_pkg::vsc_status_t            status,
    input  logic [vsc_pkg::SAMPLE_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vsc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsc_pkg::SAMPLE_W-1:0]    cfg_data
);
    import vsc_pkg::*;

    localparam int CW         = $clog2(MAX_EXTENT);
    localparam int SH_W       = $clog2(CW + 1);
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int HUE_PROD_W = LEVEL_W + HUE_IDX_W;
    localparam int RAMP_W     = LEVEL_W + COLOR_W;
    localparam int PAD_W      = M_TDATA_W - ADDR_W - 3 * COLOR_W;

    localparam hue_rom_t HUE_ROM = build_hue_rom();

    // Last valid position along an axis, with zero taken as one and large
    // values limited to the maximum extent.
    function automatic logic [CW-1:0] ext_last(input logic [EXT_W-1:0] e);
        if (e == '0) begin
            return '0;
        end
        if (32'(e) > 32'(MAX_EXTENT)) begin
            return CW'(MAX_EXTENT - 1);
        end
        return CW'(e - 1'b1);
    endfunction

    // Pitch exponent: the bit length of the last position.
    function automatic logic [SH_W-1:0] pitch_shift(input logic [CW-1:0] m);
        logic [SH_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < CW; i++) begin
            if (m[i]) begin
                sh = SH_W'(i + 1);
            end
        end
        return sh;
    endfunction

    // Configuration registers
    logic [SAMPLE_W-1:0] value_min_reg;
    logic [SAMPLE_W-1:0] value_scale_reg;
    logic                color_mode_reg;
    logic [EXT_W-1:0]    x_extent_reg;
    logic [EXT_W-1:0]    y_extent_reg;
    logic [EXT_W-1:0]    z_extent_reg;

    logic [CW-1:0] x_pos_reg, y_pos_reg, z_pos_reg;
    logic [CW-1:0] x_pos_next, y_pos_next, z_pos_next;
    logic [CW-1:0] x_last, y_last, z_last;
    logic [SH_W-1:0] x_sh, y_sh;
    logic          x_end, y_end, z_end;
    logic          cfg_we;
    logic          extent_write;

    logic [ADDR_W-1:0] plane_row;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] addr_reg;
    logic              last_reg;

    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W-1:0] diff_reg;
    logic                diff_pos_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [HUE_PROD_W-1:0] hue_prod;
    logic [HUE_ROM_AW-1:0] rom_addr_reg;
    rgb_t                  rom_data_reg;

    logic [LEVEL_W-1:0] level_inv;
    logic [RAMP_W-1:0]  red_prod;
    logic [RAMP_W-1:0]  blue_prod;
    logic [COLOR_W-1:0] ramp_red, ramp_green, ramp_blue;
    rgb_t               color;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    assign cfg_ready    = 1'b1;
    assign cfg_we       = cfg_valid;
    assign extent_write = cfg_we && (cfg_index == REG_X_EXTENT ||
                                     cfg_index == REG_Y_EXTENT ||
                                     cfg_index == REG_Z_EXTENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg   <= '0;
            value_scale_reg <= SAMPLE_W'(65536);
            color_mode_reg  <= MODE_RAMP;
            x_extent_reg    <= EXT_W'(1);
            y_extent_reg    <= EXT_W'(1);
            z_extent_reg    <= EXT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VALUE_MIN:   value_min_reg   <= cfg_data;
                REG_VALUE_SCALE: value_scale_reg <= cfg_data;
                REG_COLOR_MODE:  color_mode_reg  <= cfg_data[0];
                REG_X_EXTENT:    x_extent_reg    <= cfg_data[EXT_W-1:0];
                REG_Y_EXTENT:    y_extent_reg    <= cfg_data[EXT_W-1:0];
                REG_Z_EXTENT:    z_extent_reg    <= cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Raster position and texel address
    assign x_last = ext_last(x_extent_reg);
    assign y_last = ext_last(y_extent_reg);
    assign z_last = ext_last(z_extent_reg);
    assign x_sh   = pitch_shift(x_last);
    assign y_sh   = pitch_shift(y_last);
    assign x_end  = x_pos_reg >= x_last;
    assign y_end  = y_pos_reg >= y_last;
    assign z_end  = z_pos_reg >= z_last;

    assign plane_row = (ADDR_W'(z_pos_reg) << y_sh) + ADDR_W'(y_pos_reg);
    assign addr_next = (plane_row << x_sh) + ADDR_W'(x_pos_reg);

    always_comb begin
        x_pos_next = x_pos_reg;
        y_pos_next = y_pos_reg;
        z_pos_next = z_pos_reg;
        if (extent_write) begin
            x_pos_next = '0;
            y_pos_next = '0;
            z_pos_next = '0;
        end else if (cmd.load) begin
            if (!x_end) begin
                x_pos_next = x_pos_reg + 1'b1;
            end else begin
                x_pos_next = '0;
                if (!y_end) begin
                    y_pos_next = y_pos_reg + 1'b1;
                end else begin
                    y_pos_next = '0;
                    z_pos_next = z_end ? '0 : z_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_pos_reg <= '0;
            y_pos_reg <= '0;
            z_pos_reg <= '0;
        end else begin
            x_pos_reg <= x_pos_next;
            y_pos_reg <= y_pos_next;
            z_pos_reg <= z_pos_next;
        end
    end

    // Level arithmetic, one step per controller state.
    assign diff     = {s_tdata[SAMPLE_W-1], s_tdata} -
                      {value_min_reg[SAMPLE_W-1], value_min_reg};
    assign hue_prod = HUE_PROD_W'(level_reg) * HUE_PROD_W'(HUE_TABLE_SIZE - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_reg     <= diff[SAMPLE_W-1:0];
            diff_pos_reg <= !diff[SAMPLE_W] && (diff[SAMPLE_W-1:0] != '0);
            addr_reg     <= addr_next;
            last_reg     <= x_end && y_end && z_end;
        end
        if (cmd.mul) begin
            prod_reg <= diff_pos_reg ? PROD_W'(diff_reg) * PROD_W'(value_scale_reg) : '0;
        end
        if (cmd.level) begin
            if (prod_reg[PROD_W-1:16] > (PROD_W - 16)'(LEVEL_ONE)) begin
                level_reg <= LEVEL_ONE;
            end else begin
                level_reg <= prod_reg[16 +: LEVEL_W];
            end
        end
        if (cmd.index) begin
            rom_addr_reg <= hue_prod[16 +: HUE_ROM_AW];
        end
        if (cmd.rom) begin
            rom_data_reg <= HUE_ROM[rom_addr_reg];
        end
    end

    // Charge ramp: red falls, blue rises, green is a triangle that peaks at half.
    assign level_inv  = LEVEL_ONE - level_reg;
    assign red_prod   = RAMP_W'(level_inv) * RAMP_W'(255);
    assign blue_prod  = RAMP_W'(level_reg) * RAMP_W'(255);
    assign ramp_red   = red_prod[16 +: COLOR_W];
    assign ramp_blue  = blue_prod[16 +: COLOR_W];
    assign ramp_green = (level_reg < LEVEL_HALF) ? level_reg[8 +: COLOR_W]
                                                 : level_inv[8 +: COLOR_W];
    assign color      = (color_mode_reg == MODE_HUE) ? rom_data_reg
                                                     : {ramp_blue, ramp_green, ramp_red};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, color, addr_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tlast         = m_tlast_reg;

endmodule

// ----- sv/volume_scalar_colormap.sv -----
// The controller takes one sample at a time and accepts no new word until the last
// has been loaded into the output register; each sample passes in turn through capture,
// multiply, level, index and hue table read before the output load.
// A stalled output register holds the controller in its output state.
// Reset (aresetn low, synchronous) clears the controller, the output valid, the
// position counters and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Volume scalar colormap
// Maps raster-ordered volume samples to padded texel addresses and RGB colors.
// ----------------------------------------------------------------------------
`include "volume_scalar_colormap_macros.svh"

module volume_scalar_colormap #(
    parameter int MAX_EXTENT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample [31:0]
    input  logic [vsc_pkg::SAMPLE_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // texel_address [29:0], red [37:30], green [45:38], blue [53:46], zeros [55:54]
    output logic [vsc_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_texel
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsc_pkg::SAMPLE_W-1:0]    cfg_data
);
    import vsc_pkg::*;

    vsc_cmd_t    cmd;
    vsc_status_t status;

    vsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vsc_datapath #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Only one word may be in the datapath at a time.
    `VSC_ASSERT_NEXT(a_single_word, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a word is in flight")
    // A result never overwrites one that has not been taken.
    `VSC_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid || m_tready, "output register overwritten")
    // A loaded result is presented on the next cycle.
    `VSC_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.out_load, m_tvalid, "loaded result not presented")

endmodule
